// ----- hw/rtl/uvf_pkg.sv -----
// Shared constants, codes and types of the unique value queue.
package uvf_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned ValueW     = 31;
  localparam int unsigned InValueW   = 32;
  localparam int unsigned StatusW    = 3;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk        = 3'd0,
    StNegative  = 3'd1,
    StDuplicate = 3'd2,
    StFull      = 3'd3,
    StEmpty     = 3'd4
  } status_e;

  typedef struct packed {
    logic held;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/uvf_cell.sv -----
// One queue cell: holds a value, loads, shifts toward the head and compares.
module uvf_cell
  import uvf_pkg::*;
(
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [ValueW-1:0] load_value_i,
  input  logic [ValueW-1:0] shift_value_i,
  input  logic [ValueW-1:0] probe_i,
  output logic [ValueW-1:0] value_o,
  output logic              match_o
);

  logic [ValueW-1:0] value_q;
  logic [ValueW-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = shift_value_i;
    end else if (ctrl_i.load) begin
      value_d = load_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = ctrl_i.held && (value_q == probe_i);

endmodule

// ----- hw/rtl/uvf_chain.sv -----
// Row of queue cells with the head at cell zero.
module uvf_chain
  import uvf_pkg::*;
(
  input  logic              clk_i,
  input  logic [CountW-1:0] count_i,
  input  logic              load_i,
  input  logic              shift_i,
  input  logic [ValueW-1:0] value_i,
  output logic [ValueW-1:0] head_value_o,
  output logic              match_o
);

  logic [ValueW-1:0]     cell_value [QueueDepth];
  logic [QueueDepth-1:0] cell_match;
  cell_ctrl_t            cell_ctrl  [QueueDepth];

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic [ValueW-1:0] shift_value;

    if (i == QueueDepth - 1) begin : g_last
      assign shift_value = value_i;
    end else begin : g_inner
      assign shift_value = cell_value[i+1];
    end

    assign cell_ctrl[i].held  = count_i > CountW'(i);
    assign cell_ctrl[i].load  = load_i && (count_i == CountW'(i));
    assign cell_ctrl[i].shift = shift_i;

    uvf_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl[i]),
      .load_value_i  (value_i),
      .shift_value_i (shift_value),
      .probe_i       (value_i),
      .value_o       (cell_value[i]),
      .match_o       (cell_match[i])
    );
  end

  assign head_value_o = cell_value[0];
  assign match_o      = |cell_match;

endmodule

// ----- hw/rtl/unique_value_fifo.sv -----
// Top level of the duplicate-refusing value queue.
// A transfer's result enters the output register in the next cycle; every held cell
// compares the offered value at once. Throughput: one item per cycle while no result
// waits unaccepted. Items update count and cells at transfer, so the next one follows.
// Reset clears the occupancy count and the output valid; cell contents are not cleared.
module unique_value_fifo
  import uvf_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic signed [InValueW-1:0] in_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [StatusW-1:0]         status_o,
  output logic [ValueW-1:0]          out_value_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [ValueW-1:0] value_q, value_d;

  logic              accept;
  logic              is_insert;
  logic              negative;
  logic              duplicate;
  logic              full;
  logic              empty;
  logic              do_insert;
  logic              do_remove;
  logic [ValueW-1:0] offered;
  logic [ValueW-1:0] head_value;
  status_e           status_c;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_insert  = op_e'(operation_i) == OpInsert;
  assign offered    = in_value_i[ValueW-1:0];
  assign negative   = in_value_i[InValueW-1];
  assign full       = count_q == CountW'(QueueDepth);
  assign empty      = count_q == '0;

  uvf_chain u_chain (
    .clk_i        (clk_i),
    .count_i      (count_q),
    .load_i       (do_insert),
    .shift_i      (do_remove),
    .value_i      (offered),
    .head_value_o (head_value),
    .match_o      (duplicate)
  );

  always_comb begin
    if (is_insert) begin
      priority if (negative) begin
        status_c = StNegative;
      end else if (duplicate) begin
        status_c = StDuplicate;
      end else if (full) begin
        status_c = StFull;
      end else begin
        status_c = StOk;
      end
    end else if (empty) begin
      status_c = StEmpty;
    end else begin
      status_c = StOk;
    end
  end

  assign do_insert = accept && is_insert && (status_c == StOk);
  assign do_remove = accept && !is_insert && (status_c == StOk);

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    value_d     = value_q;
    if (do_insert) begin
      count_d = count_q + CountW'(1);
    end else if (do_remove) begin
      count_d = count_q - CountW'(1);
    end
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = status_c;
      if (status_c != StOk) begin
        value_d = '0;
      end else if (is_insert) begin
        value_d = offered;
      end else begin
        value_d = head_value;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    value_q  <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_value_o = value_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(QueueDepth))
    else $error("occupancy above queue depth");

  a_transfer_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("input transfer without a result");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_q == $past(count_q) + CountW'(1))
    else $error("accepted insert did not grow the queue");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != StOk) |-> value_q == '0)
    else $error("failed item carries a nonzero value");

endmodule

// ----- bench/testbench.sv -----
// Testbench for unique_value_fifo: directed table and random traffic against a predictor.
`timescale 1ns / 1ps

module testbench;
  import uvf_pkg::*;

  typedef struct packed {
    status_e          st;
    logic [ValueW-1:0] val;
  } result_t;

  typedef struct packed {
    op_e                 op;
    logic [InValueW-1:0] value;
    logic                typed;
    status_e             st;
    logic [ValueW-1:0]   res;
  } stim_row_t;

  localparam int NumRows = 26;

  localparam stim_row_t DirectedRows [NumRows] = '{
    '{OpRemove, 32'h0000_0000, 1'b1, StEmpty,     31'h0000_0000},
    '{OpInsert, 32'h8000_0000, 1'b1, StNegative,  31'h0000_0000},
    '{OpInsert, 32'hFFFF_FFFF, 1'b1, StNegative,  31'h0000_0000},
    '{OpInsert, 32'h0000_0000, 1'b1, StOk,        31'h0000_0000},
    '{OpInsert, 32'h0000_0000, 1'b1, StDuplicate, 31'h0000_0000},
    '{OpRemove, 32'hFFFF_FFFF, 1'b1, StOk,        31'h0000_0000},
    '{OpInsert, 32'h7FFF_FFFF, 1'b1, StOk,        31'h7FFF_FFFF},
    '{OpInsert, 32'h0000_0001, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h0000_0002, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h4000_0000, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h2AAA_AAAA, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h5555_5555, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h7FFF_FFFE, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h0000_0010, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h0001_0000, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h1234_5678, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h0F0F_0F0F, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h7000_0000, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h0000_00FF, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h3C3C_3C3C, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h6000_0001, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h0000_0003, 1'b0, StOk,        31'h0000_0000},
    '{OpInsert, 32'h0000_0004, 1'b1, StFull,      31'h0000_0000},
    '{OpInsert, 32'h7FFF_FFFF, 1'b1, StDuplicate, 31'h0000_0000},
    '{OpInsert, 32'h8000_0001, 1'b1, StNegative,  31'h0000_0000},
    '{OpRemove, 32'h0000_0000, 1'b1, StOk,        31'h7FFF_FFFF}
  };

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic                       operation_i = OpInsert;
  logic signed [InValueW-1:0] in_value_i  = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [StatusW-1:0]         status_o;
  logic [ValueW-1:0]          out_value_o;

  int      fail_count = 0;
  int      tx_mode    = 1;
  int      rx_mode    = 1;
  bit      hold_req   = 1'b0;
  bit      cur_typed  = 1'b0;
  result_t cur_want   = '0;

  logic [ValueW-1:0] held_vals[$];
  result_t           pending_results[$];

  unique_value_fifo DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .in_value_i  (in_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .out_value_o (out_value_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("%0t ERROR: %s", $realtime, msg);
  endtask

  function automatic int draw_wait(int mode);
    case (mode)
      0:       return 0;
      2:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic result_t queue_step(op_e op, logic [InValueW-1:0] raw);
    result_t r;
    bit      dup;
    r   = '{StOk, '0};
    dup = 1'b0;
    if (op == OpInsert) begin
      foreach (held_vals[k]) if (held_vals[k] == raw[ValueW-1:0]) dup = 1'b1;
      if (raw[InValueW-1]) begin
        r.st = StNegative;
      end else if (dup) begin
        r.st = StDuplicate;
      end else if (held_vals.size() >= QueueDepth) begin
        r.st = StFull;
      end else begin
        held_vals.push_back(raw[ValueW-1:0]);
        r.val = raw[ValueW-1:0];
      end
    end else if (held_vals.size() == 0) begin
      r.st = StEmpty;
    end else begin
      r.val = held_vals.pop_front();
    end
    return r;
  endfunction

  task automatic send_item(op_e op, logic [InValueW-1:0] value, bit typed, result_t want);
    int gap;
    gap = draw_wait(tx_mode);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    in_value_i  <= value;
    cur_typed   = typed;
    cur_want    = want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  always @(posedge clk_i) begin : monitor
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer: status %0d value %h",
                                    status_o, out_value_o));
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.st)
            report_mismatch($sformatf("status %0d, want %0d", status_o, want.st));
          if (out_value_o !== want.val)
            report_mismatch($sformatf("out_value %h, want %h", out_value_o, want.val));
        end
      end
      if (in_valid_i && in_ready_o) begin
        got = queue_step(op_e'(operation_i), in_value_i);
        pending_results.push_back(cur_typed ? cur_want : got);
      end
    end
  end

  initial begin : receiver
    int stall_cnt;
    stall_cnt = 0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= (stall_cnt == 0);
      if (stall_cnt > 0) stall_cnt--;
      @(posedge clk_i);
      if (hold_req) begin
        stall_cnt = 90;
        hold_req  = 1'b0;
      end else if (out_valid_o && out_ready_i) begin
        stall_cnt = draw_wait(rx_mode);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("unique_value_fifo: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [InValueW-1:0] value;
    op_e                 op;
    int                  ins_pct;
    int                  kind;
    int                  w;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[r])
      send_item(DirectedRows[r].op, DirectedRows[r].value, DirectedRows[r].typed,
                '{DirectedRows[r].st, DirectedRows[r].res});

    for (int chunk = 0; chunk < 12; chunk++) begin
      tx_mode = chunk % 3;
      rx_mode = (chunk == 0) ? 1 : $urandom_range(0, 2);
      case (chunk % 4)
        0:       ins_pct = 85;
        1:       ins_pct = 50;
        2:       ins_pct = 20;
        default: ins_pct = 60;
      endcase
      // hold the receiver off while the sender keeps offering
      if (chunk == 0) hold_req = 1'b1;
      for (int i = 0; i < 100; i++) begin
        op   = ($urandom_range(0, 99) < ins_pct) ? OpInsert : OpRemove;
        kind = $urandom_range(0, 99);
        if (op == OpRemove)
          value = $urandom();
        else if (kind < 8)
          value = {1'b1, 31'($urandom())};
        else if (kind < 38 && held_vals.size() > 0)
          value = {1'b0, held_vals[$urandom_range(0, held_vals.size() - 1)]};
        else if (kind < 75)
          value = 32'($urandom_range(0, 40));
        else
          value = {1'b0, 31'($urandom())};
        send_item(op, value, 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (w = 0; w < 5000 && pending_results.size() > 0; w++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("unique_value_fifo: match");
    end else begin
      $display("unique_value_fifo: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/uvf_pkg.sv
hw/rtl/uvf_cell.sv
hw/rtl/uvf_chain.sv
hw/rtl/unique_value_fifo.sv
bench/testbench.sv
